/* rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register indexes and item types of the ray/sphere tester.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int DIR_FRAC_BITS_DEF   = 14;

	localparam int CW   = 32;   // coordinate width
	localparam int UW   = 16;   // direction / normal width
	localparam int RW   = 31;   // radius and distance width
	localparam int DLW  = 33;   // origin minus center
	localparam int HW   = 51;   // half of b, worst case over the fraction range
	localparam int JW   = 5;    // root rescale steps
	localparam int IN_W = 144;
	localparam int OUT_W = 80;
	localparam int QDEPTH = 4;

	localparam logic [63:0] DISC_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [RW-1:0] DIST_MAX = '1;

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;
	localparam logic [1:0] REG_RADIUS   = 2'd3;

	typedef struct packed {
		logic                  ok;
		logic [JW-1:0]         j;
		logic signed [HW-1:0]  h;
		logic signed [DLW-1:0] dx;
		logic signed [DLW-1:0] dy;
		logic signed [DLW-1:0] dz;
		logic signed [UW-1:0]  ux;
		logic signed [UW-1:0]  uy;
		logic signed [UW-1:0]  uz;
	} ray_t;

	typedef struct packed {
		ray_t        ray;
		logic [63:0] rad;
	} front_t;

endpackage

/* rtl/rsi_front.sv */
// ----------------------------------------------------------------------------
// rsi_front
// Accepts rays, forms h, c and the discriminant, classifies the item and
// prepares the scaled radicand for the root unit.
// ----------------------------------------------------------------------------
module rsi_front #(
	parameter int COORD_FRAC_BITS = rsi_pkg::COORD_FRAC_BITS_DEF,
	parameter int DIR_FRAC_BITS   = rsi_pkg::DIR_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rsi_pkg::IN_W-1:0]       in_data,
	input  logic signed [rsi_pkg::CW-1:0]  center_x,
	input  logic signed [rsi_pkg::CW-1:0]  center_y,
	input  logic signed [rsi_pkg::CW-1:0]  center_z,
	input  logic [rsi_pkg::RW-1:0]         radius,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rsi_pkg::front_t                out_item
);
	import rsi_pkg::*;

	localparam int CCW = 66;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [CW-1:0]  o [3];
	logic signed [CW-1:0]  cen [3];
	logic signed [UW-1:0]  u [3];
	logic signed [DLW-1:0] d_s1 [3];
	logic signed [UW-1:0]  u_s1 [3];
	logic [61:0]           rr_s1;

	logic signed [48:0]    pd_s2 [3];
	logic [63:0]           sq_s2 [3];
	logic [61:0]           rr_s2;
	ray_t                  r_s2, r_s3, r_s4, r_s5, r_s6;

	logic signed [HW-1:0]  dot;
	logic signed [CCW-1:0] c_s3, c_s4;
	logic [HW-1:0]         ha;
	logic [63:0]           hp;
	logic [63:0]           hh_s4;
	logic signed [CCW-1:0] disc;
	logic [63:0]           disc_s5;
	logic                  found;
	logic [JW-1:0]         jsel;
	logic [63:0]           rad_c, rad_s6;

	// advance whenever the last stage is empty or drains into the queue
	assign en        = !v_s6 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// unpack the item
	always_comb begin
		cen[0] = center_x;
		cen[1] = center_y;
		cen[2] = center_z;
		for (int i = 0; i < 3; i++) begin
			o[i] = $signed(in_data[i*CW +: CW]);
			u[i] = $signed(in_data[3*CW + i*UW +: UW]);
		end
	end

	// stage 1: offset from the center, radius squared
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DLW'(o[i]) - DLW'(cen[i]);
				u_s1[i] <= u[i];
			end
			rr_s1 <= radius * radius;
		end
	end

	// stage 2: products for the dot product and the squared length
	always_ff @(posedge clk) begin
		logic [DLW-1:0] dm;
		logic [63:0]    sqp;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= d_s1[i] * u_s1[i];
				dm = d_s1[i][DLW-1] ? DLW'(-d_s1[i]) : DLW'(d_s1[i]);
				sqp = {32'b0, dm[31:0]} * {32'b0, dm[31:0]};
				sq_s2[i] <= sqp >> COORD_FRAC_BITS;
			end
			rr_s2   <= rr_s1 >> COORD_FRAC_BITS;
			r_s2.ok <= 1'b0;
			r_s2.j  <= '0;
			r_s2.h  <= '0;
			r_s2.dx <= d_s1[0];
			r_s2.dy <= d_s1[1];
			r_s2.dz <= d_s1[2];
			r_s2.ux <= u_s1[0];
			r_s2.uy <= u_s1[1];
			r_s2.uz <= u_s1[2];
		end
	end

	// stage 3: h and c
	assign dot = HW'(pd_s2[0]) + HW'(pd_s2[1]) + HW'(pd_s2[2]);

	always_ff @(posedge clk) begin
		ray_t r_nx;
		if (en) begin
			r_nx   = r_s2;
			r_nx.h = dot >>> DIR_FRAC_BITS;
			r_s3   <= r_nx;
			c_s3   <= $signed(CCW'(sq_s2[0]) + CCW'(sq_s2[1]) + CCW'(sq_s2[2])
				- CCW'(rr_s2));
		end
	end

	// stage 4: saturating h squared
	assign ha = r_s3.h[HW-1] ? HW'(-r_s3.h) : HW'(r_s3.h);
	assign hp = {32'b0, ha[31:0]} * {32'b0, ha[31:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4  <= r_s3;
			c_s4  <= c_s3;
			hh_s4 <= (|ha[HW-1:32]) ? DISC_LIM : (hp >> COORD_FRAC_BITS);
		end
	end

	// stage 5: discriminant, classify
	assign disc = $signed(CCW'(hh_s4)) - c_s4;

	always_ff @(posedge clk) begin
		ray_t r_nx;
		if (en) begin
			r_nx    = r_s4;
			r_nx.ok = disc > 0;
			r_s5    <= r_nx;
			disc_s5 <= (disc > $signed(CCW'(DISC_LIM))) ? DISC_LIM : disc[63:0];
		end
	end

	// stage 6: pick the largest even pre-scale that keeps the radicand in range
	always_comb begin
		found = 1'b0;
		jsel  = '0;
		for (int jj = 0; jj <= COORD_FRAC_BITS / 2; jj++) begin
			if (!found && ((COORD_FRAC_BITS - 2*jj) <= 1 ||
				disc_s5 <= (64'hFFFF_FFFF_FFFF_FFFF >> (COORD_FRAC_BITS - 2*jj)))) begin
				found = 1'b1;
				jsel  = JW'(jj);
			end
		end
		rad_c = disc_s5 << (COORD_FRAC_BITS - 2*int'(jsel));
	end

	always_ff @(posedge clk) begin
		ray_t r_nx;
		if (en) begin
			r_nx   = r_s5;
			r_nx.j = jsel;
			r_s6   <= r_nx;
			rad_s6 <= rad_c;
		end
	end

	assign out_item.ray = r_s6;
	assign out_item.rad = rad_s6;

endmodule

/* rtl/rsi_fifo.sv */
// ----------------------------------------------------------------------------
// rsi_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module rsi_fifo #(
	parameter int DEPTH = rsi_pkg::QDEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rsi_pkg::front_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output rsi_pkg::front_t out_item
);
	import rsi_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	front_t         mem_q [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [AW:0]    cnt_q;
	logic           push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rptr_q];

	// store the item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

/* rtl/rsi_isqrt.sv */
// ----------------------------------------------------------------------------
// rsi_isqrt
// Pipelined integer square root of a 64-bit value, two radicand bits a stage.
// ----------------------------------------------------------------------------
module rsi_isqrt #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [63:0]   in_rad,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [31:0]   out_root,
	output logic [SW-1:0] out_side
);
	localparam int NST = 32;

	logic          v_q    [NST];
	logic [35:0]   rem_q  [NST];
	logic [31:0]   root_q [NST];
	logic [63:0]   rad_q  [NST];
	logic [SW-1:0] side_q [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic          p_v;
		logic [35:0]   p_rem;
		logic [31:0]   p_root;
		logic [63:0]   p_rad;
		logic [SW-1:0] p_side;
		logic [35:0]   a, trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign p_v    = in_valid;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = in_rad;
			assign p_side = in_side;
		end else begin : g_next
			assign p_v    = v_q[k-1];
			assign p_rem  = rem_q[k-1];
			assign p_root = root_q[k-1];
			assign p_rad  = rad_q[k-1];
			assign p_side = side_q[k-1];
		end

		// try to subtract 4*root+1 from the shifted remainder
		assign a     = {p_rem[33:0], p_rad[63:62]};
		assign trial = {2'b00, p_root, 2'b01};
		assign ge    = a >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? a - trial : a;
				root_q[k] <= {p_root[30:0], ge};
				rad_q[k]  <= {p_rad[61:0], 2'b00};
				side_q[k] <= p_side;
			end
		end
	end

	assign out_valid = v_q[NST-1];
	assign out_root  = root_q[NST-1];
	assign out_side  = side_q[NST-1];

endmodule

/* rtl/rsi_div.sv */
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider, three numerators over one shared divisor,
// one quotient bit a stage.
// ----------------------------------------------------------------------------
module rsi_div #(
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][63:0]      in_num,
	input  logic [31:0]           in_den,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output logic [2:0][QW-1:0]    out_q,
	output logic [SW-1:0]         out_side
);
	logic          v_q    [QW];
	logic [31:0]   den_q  [QW];
	logic [SW-1:0] side_q [QW];
	logic [31:0]   rem_q  [3][QW];
	logic [QW-1:0] nb_q   [3][QW];
	logic [QW-1:0] quo_q  [3][QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic          p_v;
		logic [31:0]   p_den;
		logic [SW-1:0] p_side;

		if (k == 0) begin : g_first
			assign p_v    = in_valid;
			assign p_den  = in_den;
			assign p_side = in_side;
		end else begin : g_next
			assign p_v    = v_q[k-1];
			assign p_den  = den_q[k-1];
			assign p_side = side_q[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k]  <= p_den;
				side_q[k] <= p_side;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [31:0]   p_rem;
			logic [QW-1:0] p_nb;
			logic [QW-1:0] p_quo;
			logic [32:0]   a;
			logic          ge;

			if (k == 0) begin : g_first
				logic [63:0] hi;
				assign hi    = in_num[l] >> QW;
				assign p_rem = hi[31:0];
				assign p_nb  = in_num[l][QW-1:0];
				assign p_quo = '0;
			end else begin : g_next
				assign p_rem = rem_q[l][k-1];
				assign p_nb  = nb_q[l][k-1];
				assign p_quo = quo_q[l][k-1];
			end

			// bring down one numerator bit and subtract when it fits
			assign a  = {p_rem, p_nb[QW-1]};
			assign ge = a >= {1'b0, p_den};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[l][k] <= ge ? 32'(a - {1'b0, p_den}) : a[31:0];
					nb_q[l][k]  <= p_nb << 1;
					quo_q[l][k] <= {p_quo[QW-2:0], ge};
				end
			end

			assign out_q[l] = quo_q[l][QW-1];
		end
	end

	assign out_valid = v_q[QW-1];
	assign out_side  = side_q[QW-1];

endmodule

/* rtl/rsi_back.sv */
// ----------------------------------------------------------------------------
// rsi_back
// Takes classified items from the queue: root of the discriminant, hit
// distance, hit point, its length and the normalized normal.
// ----------------------------------------------------------------------------
module rsi_back #(
	parameter int COORD_FRAC_BITS = rsi_pkg::COORD_FRAC_BITS_DEF,
	parameter int DIR_FRAC_BITS   = rsi_pkg::DIR_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rsi_pkg::front_t           in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rsi_pkg::OUT_W-1:0] out_data
);
	import rsi_pkg::*;

	localparam int TW = 54;
	localparam int PW = 49;
	localparam int KW = 6;
	localparam int QW = DIR_FRAC_BITS + 2;

	typedef struct packed {
		logic             hit;
		logic [RW-1:0]    t;
		logic [2:0]       neg;
		logic [2:0][29:0] m;
	} nrm_t;

	typedef struct packed {
		logic          hit;
		logic [RW-1:0] t;
		logic [2:0]    neg;
		logic          lenz;
	} div_t;

	logic en;
	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic        v_r1;
	logic [31:0] root1;
	ray_t        ray1;

	logic signed [TW-1:0] sroot, nh, r1, r2, tt;
	logic v_b1, v_b2, v_b3, v_b4, v_b5;
	logic hit_b1, hit_b2, hit_b3, hit_b4, hit_b5;
	logic [RW-1:0] t_b1, t_b2, t_b3, t_b4, t_b5;
	logic signed [DLW-1:0] d1 [3];
	logic signed [UW-1:0]  u1 [3];
	logic signed [DLW-1:0] d_b1 [3], d_b2 [3];
	logic signed [UW-1:0]  u_b1 [3];
	logic signed [47:0]    prod_b2 [3];
	logic [PW-1:0]         m_b3 [3];
	logic [2:0]            neg_b3, neg_b4, neg_b5;
	logic [PW-1:0]         mx;
	logic [KW-1:0]         k;
	logic [29:0]           ms_b4 [3], ms_b5 [3];
	logic [59:0]           sq_b5 [3];

	nrm_t        side2_in, side2;
	logic        v_r2;
	logic [31:0] len;
	logic [63:0] sum_sq;

	logic [2:0][63:0] num;
	div_t             dside_in, dside;
	logic             v_d;
	logic [2:0][QW-1:0] quo;
	logic [UW-1:0]    nrm [3];

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	function automatic logic [UW-1:0] sat_norm(logic [QW-1:0] q, logic neg, logic lz);
		logic [32:0] qe;
		logic [32:0] nq;
		qe = 33'(q);
		nq = -qe;
		if (lz) begin
			return '0;
		end else if (neg) begin
			return (qe > 33'd32768) ? 16'h8000 : nq[UW-1:0];
		end else begin
			return (qe > 33'd32767) ? 16'h7FFF : qe[UW-1:0];
		end
	endfunction

	// root of the discriminant
	rsi_isqrt #(.SW($bits(ray_t))) u_sqrt_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_rad   (in_item.rad),
		.in_side  (in_item.ray),
		.out_valid(v_r1),
		.out_root (root1),
		.out_side (ray1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
		end else if (en) begin
			v_b1 <= v_r1;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
		end
	end

	// stage 1: nearer root less one LSB if positive, else farther root less one LSB
	always_comb begin
		sroot = $signed(TW'(root1) << ray1.j);
		nh    = -TW'(ray1.h);
		r1    = nh - sroot - TW'(1);
		r2    = nh + sroot - TW'(1);
		tt    = (r1 > 0) ? r1 : r2;
		d1[0] = ray1.dx;
		d1[1] = ray1.dy;
		d1[2] = ray1.dz;
		u1[0] = ray1.ux;
		u1[1] = ray1.uy;
		u1[2] = ray1.uz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_b1 <= ray1.ok && !tt[TW-1];
			t_b1   <= (tt > $signed(TW'(DIST_MAX))) ? DIST_MAX : tt[RW-1:0];
			for (int i = 0; i < 3; i++) begin
				d_b1[i] <= d1[i];
				u_b1[i] <= u1[i];
			end
		end
	end

	// stage 2: direction times distance
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_b2[i] <= u_b1[i] * $signed({1'b0, t_b1});
				d_b2[i]    <= d_b1[i];
			end
			hit_b2 <= hit_b1;
			t_b2   <= t_b1;
		end
	end

	// stage 3: hit point relative to the center, magnitude and sign
	always_ff @(posedge clk) begin
		logic signed [PW-1:0] p;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p = PW'(d_b2[i]) + PW'(prod_b2[i] >>> DIR_FRAC_BITS);
				m_b3[i]   <= p[PW-1] ? PW'(-p) : PW'(p);
				neg_b3[i] <= p[PW-1];
			end
			hit_b3 <= hit_b2;
			t_b3   <= t_b2;
		end
	end

	// stage 4: scale all components down until the largest fits 30 bits
	always_comb begin
		mx = m_b3[0];
		if (m_b3[1] > mx) begin
			mx = m_b3[1];
		end
		if (m_b3[2] > mx) begin
			mx = m_b3[2];
		end
		k = '0;
		for (int kk = 0; kk <= PW - 31; kk++) begin
			if (mx[kk + 30]) begin
				k = KW'(kk + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [PW-1:0] sh;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sh = m_b3[i] >> k;
				ms_b4[i] <= sh[29:0];
			end
			neg_b4 <= neg_b3;
			hit_b4 <= hit_b3;
			t_b4   <= t_b3;
		end
	end

	// stage 5: squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_b5[i] <= 60'(ms_b4[i]) * 60'(ms_b4[i]);
				ms_b5[i] <= ms_b4[i];
			end
			neg_b5 <= neg_b4;
			hit_b5 <= hit_b4;
			t_b5   <= t_b4;
		end
	end

	// length of the hit point vector
	assign sum_sq       = 64'(sq_b5[0]) + 64'(sq_b5[1]) + 64'(sq_b5[2]);
	assign side2_in.hit = hit_b5;
	assign side2_in.t   = t_b5;
	assign side2_in.neg = neg_b5;
	assign side2_in.m   = {ms_b5[2], ms_b5[1], ms_b5[0]};

	rsi_isqrt #(.SW($bits(nrm_t))) u_sqrt_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_b5),
		.in_rad   (sum_sq),
		.in_side  (side2_in),
		.out_valid(v_r2),
		.out_root (len),
		.out_side (side2)
	);

	// rounded quotients component / length
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = (64'(side2.m[i]) << DIR_FRAC_BITS) + 64'(len >> 1);
		end
		dside_in.hit  = side2.hit;
		dside_in.t    = side2.t;
		dside_in.neg  = side2.neg;
		dside_in.lenz = len == '0;
	end

	rsi_div #(.QW(QW), .SW($bits(div_t))) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_r2),
		.in_num   (num),
		.in_den   (len),
		.in_side  (dside_in),
		.out_valid(v_d),
		.out_q    (quo),
		.out_side (dside)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm[i] = sat_norm(quo[i], dside.neg[i], dside.lenz);
		end
	end

	// output register; a miss reports all fields zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= dside.hit ? {nrm[2], nrm[1], nrm[0], dside.t, 1'b1} : '0;
		end
	end

endmodule

/* rtl/ray_sphere_intersect.sv */
// Stages from input accept to result (each root and division step has its own):
//   6 front stages, 1 queue, 32 root stages, 5 hit-point stages, 32 length
//   root stages, DIR_FRAC_BITS + 2 divider stages, 1 output register.
// Throughput: one ray per cycle while the output is not stalled.
// Reset (arst_n low, asynchronous): pipeline and queue empty, center 0,
//   radius 1.0.
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray/sphere hit test with distance and unit normal; sphere set by registers.
// ----------------------------------------------------------------------------
module ray_sphere_intersect #(
	parameter int COORD_FRAC_BITS = rsi_pkg::COORD_FRAC_BITS_DEF,
	parameter int DIR_FRAC_BITS   = rsi_pkg::DIR_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [rsi_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// hit, distance, normal_x, normal_y, normal_z
	output logic [rsi_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);
	import rsi_pkg::*;

	logic signed [CW-1:0] center_x_q, center_y_q, center_z_q;
	logic [RW-1:0]        radius_q;

	logic   f_valid, f_ready, q_valid, q_ready;
	front_t f_item, q_item;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RW'(1) << COORD_FRAC_BITS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CENTER_X: center_x_q <= $signed(cfg_data);
				REG_CENTER_Y: center_y_q <= $signed(cfg_data);
				REG_CENTER_Z: center_z_q <= $signed(cfg_data);
				REG_RADIUS:   radius_q   <= cfg_data[RW-1:0];
			endcase
		end
	end

	rsi_front #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.DIR_FRAC_BITS  (DIR_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.center_z (center_z_q),
		.radius   (radius_q),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_item (f_item)
	);

	rsi_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_item  (f_item),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_item (q_item)
	);

	rsi_back #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.DIR_FRAC_BITS  (DIR_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

/* rtl/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_sva
// Port-level checks of the ray/sphere tester, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_sva (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [rsi_pkg::OUT_W-1:0] m_axis_tdata
);
	import rsi_pkg::*;

	logic [7:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// count items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_W-1:1] == '0)
		else $error("miss with nonzero fields");

	// no result without an outstanding item
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != '0)
		else $error("result without an item");

endmodule

bind ray_sphere_intersect rsi_sva u_rsi_sva (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

/* verif/rsi_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsi_checker
// Watches the ray, result and register channels of the ray/sphere tester,
// computes the expected hit, distance and normal of every accepted ray and
// compares each returned result with the oldest expected one.
// ----------------------------------------------------------------------------
module rsi_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [rsi_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [rsi_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        hits_seen,
	output int                        results_seen
);
	import rsi_pkg::*;

	localparam int F = 16;
	localparam int G = 14;
	localparam logic [63:0] SAT = 64'h3FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} result_t;

	longint sph_cx, sph_cy, sph_cz;
	longint unsigned sph_r;
	result_t hit_queue[$];

	function automatic longint fdiv(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic result_t trace_ray(logic [IN_W-1:0] ray);
		longint d[3], dv[3], p[3], h, c, disc, s, t, r1;
		longint unsigned sq, rr, m[3], mx, len, hm, q;
		logic [127:0] prod;
		int e, k;
		result_t res;
		res = '0;
		d[0] = longint'($signed(ray[31:0])) - sph_cx;
		d[1] = longint'($signed(ray[63:32])) - sph_cy;
		d[2] = longint'($signed(ray[95:64])) - sph_cz;
		dv[0] = longint'($signed(ray[111:96]));
		dv[1] = longint'($signed(ray[127:112]));
		dv[2] = longint'($signed(ray[143:128]));
		h = fdiv(d[0] * dv[0] + d[1] * dv[1] + d[2] * dv[2], G);
		sq = 0;
		for (int i = 0; i < 3; i++) sq += (mag64(d[i]) * mag64(d[i])) >> F;
		rr = (sph_r * sph_r) >> F;
		c = longint'(sq) - longint'(rr);
		hm = mag64(h);
		prod = 128'(hm) * 128'(hm);
		if (prod[127:64] != 0) hm = SAT;
		else begin
			hm = prod[63:0] >> F;
			if (hm > SAT) hm = SAT;
		end
		disc = longint'(hm) - c;
		if (disc > longint'(SAT)) disc = longint'(SAT);
		if (disc <= 0) return res;
		e = F;
		while (e > 1 && 64'(disc) > (64'hFFFF_FFFF_FFFF_FFFF >> e)) e -= 2;
		s = longint'(int_sqrt(64'(disc) << e) << ((F - e) / 2));
		r1 = -h - s - 1;
		t = r1 > 0 ? r1 : s - h - 1;
		if (t < 0) return res;
		if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			p[i] = d[i] + fdiv(dv[i] * t, G);
			m[i] = mag64(p[i]);
			if (m[i] > mx) mx = m[i];
		end
		k = 0;
		while ((mx >> k) >= (64'd1 << 30)) k++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] >>= k;
			sq += m[i] * m[i];
		end
		len = int_sqrt(sq);
		res.hit = 1'b1;
		res.distance = t[30:0];
		for (int i = 0; i < 3; i++) begin
			logic [15:0] nv;
			q = 0;
			if (len != 0) q = ((m[i] << G) + len / 2) / len;
			if (p[i] < 0) nv = q > 32768 ? 16'h8000 : 16'(-longint'(q));
			else nv = q > 32767 ? 16'h7FFF : 16'(q);
			if (i == 0) res.nx = nv;
			else if (i == 1) res.ny = nv;
			else res.nz = nv;
		end
		return res;
	endfunction

	// Track registers, predict on each accepted ray, compare each result
	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			sph_cx <= 0;
			sph_cy <= 0;
			sph_cz <= 0;
			sph_r <= 65536;
			errors <= 0;
			pending <= 0;
			hits_seen <= 0;
			results_seen <= 0;
			hit_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CENTER_X: sph_cx <= longint'($signed(cfg_data));
					REG_CENTER_Y: sph_cy <= longint'($signed(cfg_data));
					REG_CENTER_Z: sph_cz <= longint'($signed(cfg_data));
					REG_RADIUS:   sph_r <= {33'd0, cfg_data[30:0]};
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				hit_queue.push_back(trace_ray(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'({m_axis_tdata[79:48], m_axis_tdata[47:32],
					m_axis_tdata[31:0]});
				got.hit = m_axis_tdata[0];
				got.distance = m_axis_tdata[31:1];
				got.nx = m_axis_tdata[47:32];
				got.ny = m_axis_tdata[63:48];
				got.nz = m_axis_tdata[79:64];
				results_seen <= results_seen + 1;
				if (got.hit) hits_seen <= hits_seen + 1;
				if (hit_queue.size() == 0) begin
					if (errors < 10) $display("%0t: result with none expected: %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = hit_queue.pop_front();
					if (want != got) begin
						if (errors < 10)
							$display("%0t: mismatch exp hit=%0d t=%h n=%h,%h,%h got hit=%0d t=%h n=%h,%h,%h",
								$time, want.hit, want.distance, want.nx, want.ny, want.nz,
								got.hit, got.distance, got.nx, got.ny, got.nz);
						errors <= errors + 1;
					end
				end
			end
			pending <= hit_queue.size();
		end
	end

endmodule

/* verif/tb_ray_sphere_intersect.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect
// Drives rays and sphere settings into the ray/sphere tester under random
// flow control; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect;
	import rsi_pkg::*;

	localparam int SETTLE = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_CENTER_X;
	logic [31:0] cfg_data = '0;

	int errors, pending, hits_seen, results_seen;
	int send_idle = 0;
	int recv_stall = 0;
	int rays_sent = 0;

	ray_sphere_intersect i_dut (.*);

	rsi_checker i_checker (.*);

	always #5 clk = ~clk;

	// Randomly stall the result side
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
		logic [30:0] r);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, {1'b0, r});
	endtask

	// Present one ray; valid stays high across back-to-back items
	task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {dz, dy, dx, oz, oy, ox};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		rays_sent++;
	endtask

	function automatic logic [15:0] unit_comp();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// Mostly aimed rays near the sphere, some fully random
	task automatic random_ray(int scale);
		logic [31:0] ox, oy, oz;
		logic [15:0] dx, dy, dz;
		int sel;
		sel = $urandom_range(9);
		ox = $urandom; oy = $urandom; oz = $urandom;
		dx = 16'($urandom); dy = 16'($urandom); dz = 16'($urandom);
		if (sel < 8) begin
			ox = 32'($signed(i_checker.sph_cx) + ($signed($urandom) >>> scale));
			oy = 32'($signed(i_checker.sph_cy) + ($signed($urandom) >>> scale));
			oz = 32'($signed(i_checker.sph_cz) + ($signed($urandom) >>> scale));
			case ($urandom_range(2))
				0: begin dx = ox[31] ? 16'd16384 : 16'hC000; dy = 0; dz = 0; end
				1: begin dx = unit_comp(); dy = unit_comp(); dz = 16'd9000; end
				default: begin dx = 16'd9459; dy = 16'd9459; dz = 16'd9459; end
			endcase
		end
		send_ray(ox, oy, oz, dx, dy, dz);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed rays at the reset sphere (unit sphere at the origin)
		send_ray(32'hFFFB_0000, 0, 0, 16'd16384, 0, 0);
		send_ray(0, 0, 0, 16'd16384, 0, 0);
		send_ray(0, 0, 0, 0, 16'hC000, 0);
		send_ray(0, 32'h0001_0000, 0, 0, 0, 16'd16384);
		send_ray(32'h0005_0000, 0, 0, 16'd16384, 0, 0);
		send_ray(32'h0005_0000, 0, 0, 16'hC000, 0, 0);
		send_ray(32'h0003_0000, 32'h0003_0000, 0, 0, 0, 16'd16384);
		send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
		send_ray(32'hFFFF_0000, 0, 0, 16'h7FFF, 0, 0);
		send_ray(32'h7FFF_FFFF, 0, 0, 16'h8000, 0, 0);
		send_ray(0, 0, 32'hFFF0_0000, 0, 0, 0);
		drain();

		// Radius zero, ray through the center
		set_sphere(32'h0002_0000, 0, 0, 31'd0);
		send_ray(0, 0, 0, 16'd16384, 0, 0);
		send_ray(32'hFFF0_0000, 0, 0, 16'd16384, 0, 0);
		drain();

		// Huge sphere: saturated distance and extreme coordinates
		set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
		send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd16384, 0, 0);
		send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_ray(0, 0, 0, 16'd5, 0, 0);
		drain();

		// Random phases over several sphere settings and flow patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 49; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 49; end
				default: begin send_idle = 15; recv_stall = 15; end
			endcase
			case (ph)
				0: set_sphere(0, 0, 0, 31'h0001_0000);
				1: set_sphere($urandom >> 8, $urandom >> 8, $urandom >> 8,
					31'($urandom >> 9));
				7: set_sphere($urandom, $urandom, $urandom, 31'($urandom));
				default: set_sphere($urandom >> 4, $urandom >> 4, $urandom >> 4,
					31'($urandom_range(31'h7FFF_FFFF)));
			endcase
			for (int n = 0; n < 128; n++) random_ray($urandom_range(1, 14));
			drain();
		end
		send_idle = 0;
		recv_stall = 0;

		$display("Sent %0d rays, checked %0d results of which %0d were hits.",
			rays_sent, results_seen, hits_seen);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_fifo.sv
rtl/rsi_isqrt.sv
rtl/rsi_div.sv
rtl/rsi_back.sv
rtl/ray_sphere_intersect.sv
rtl/rsi_checker.sv
verif/rsi_checker.sv
verif/tb_ray_sphere_intersect.sv
